// ===== rtl/lss_pkg.sv =====
// Shared types and constants for the two-sensor line steering block.
package lss_pkg;

  // Field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned DutyW   = 5;
  localparam int unsigned PosW    = 3;
  localparam int unsigned DepthW  = 2;
  localparam int unsigned StepW   = SampleW - 2;
  localparam int unsigned LimitW  = SampleW + 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT_HIGH  = 2'd0;
  localparam logic [1:0] REG_LEFT_LOW   = 2'd1;
  localparam logic [1:0] REG_RIGHT_HIGH = 2'd2;
  localparam logic [1:0] REG_RIGHT_LOW  = 2'd3;

  // Reduced duty on the slow side of each band.
  localparam logic [DutyW-1:0] DUTY_BAND1 = 5'd3;
  localparam logic [DutyW-1:0] DUTY_BAND2 = 5'd7;
  localparam logic [DutyW-1:0] DUTY_BAND3 = 5'd11;
  localparam logic [DutyW-1:0] DUTY_FIELD_MAX = 5'd31;

  // Band depth codes.
  localparam logic [DepthW-1:0] DEPTH_CENTER = 2'd0;
  localparam logic [DepthW-1:0] DEPTH_BAND3  = 2'd1;
  localparam logic [DepthW-1:0] DEPTH_BAND2  = 2'd2;
  localparam logic [DepthW-1:0] DEPTH_BAND1  = 2'd3;

  // Line position codes.
  localparam logic signed [PosW-1:0] POS_LEFT3  = -3'sd3;
  localparam logic signed [PosW-1:0] POS_LEFT2  = -3'sd2;
  localparam logic signed [PosW-1:0] POS_LEFT1  = -3'sd1;
  localparam logic signed [PosW-1:0] POS_CENTER = 3'sd0;
  localparam logic signed [PosW-1:0] POS_RIGHT1 = 3'sd1;
  localparam logic signed [PosW-1:0] POS_RIGHT2 = 3'sd2;
  localparam logic signed [PosW-1:0] POS_RIGHT3 = 3'sd3;

  // Band membership of one sensor sample.
  typedef struct packed {
    logic band1;
    logic band2;
    logic band3;
  } band_flags_t;

  // One steering result.
  typedef struct packed {
    logic [DepthW-1:0]        depth_level;
    logic signed [PosW-1:0]   line_position;
    logic [DutyW-1:0]         right_duty;
    logic [DutyW-1:0]         left_duty;
  } steer_result_t;

endpackage

// ===== rtl/two_sensor_line_steering.sv =====
// Top level of the two-sensor banded line steering block.
// An accepted input transaction goes into the input register, then the result register,
// where its result is offered; the band compare and priority chain sit in one stage between.
// Throughput: one transaction per cycle while out_tready does not stall the result register.
// The kept band depth updates as each result is loaded, so back-to-back samples see it in order.
// Reset (rst_n, synchronous, active low): both stages empty, depth 0, calibration
// high readings 65535 and low readings 0.
module two_sensor_line_steering #(
  parameter int unsigned DUTY_MAX = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] left_sample, [31:16] right_sample
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] left_duty, [9:5] right_duty,
                                  // [12:10] line_position, [14:13] depth_level, [15] zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned FullDutyInt =
    (DUTY_MAX > 31) ? 31 : DUTY_MAX;
  localparam logic [lss_pkg::DutyW-1:0] FullDuty = FullDutyInt[lss_pkg::DutyW-1:0];

  logic [lss_pkg::SampleW-1:0] left_high_r, left_high_nxt;
  logic [lss_pkg::SampleW-1:0] left_low_r, left_low_nxt;
  logic [lss_pkg::SampleW-1:0] right_high_r, right_high_nxt;
  logic [lss_pkg::SampleW-1:0] right_low_r, right_low_nxt;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [lss_pkg::SampleW-1:0] s1_left_r;
  logic [lss_pkg::SampleW-1:0] s1_right_r;
  logic                        out_valid_r, out_valid_nxt;
  lss_pkg::steer_result_t      out_result_r;
  logic [lss_pkg::DepthW-1:0]  band_depth_r, band_depth_nxt;

  logic                        in_take;
  logic                        s1_advance;
  lss_pkg::band_flags_t        left_flags;
  lss_pkg::band_flags_t        right_flags;
  lss_pkg::steer_result_t      step_result;

  // Calibration register writes.
  always_comb begin
    left_high_nxt  = left_high_r;
    left_low_nxt   = left_low_r;
    right_high_nxt = right_high_r;
    right_low_nxt  = right_low_r;
    if (cfg_we) begin
      case (cfg_addr)
        lss_pkg::REG_LEFT_HIGH:  left_high_nxt  = cfg_wdata;
        lss_pkg::REG_LEFT_LOW:   left_low_nxt   = cfg_wdata;
        lss_pkg::REG_RIGHT_HIGH: right_high_nxt = cfg_wdata;
        lss_pkg::REG_RIGHT_LOW:  right_low_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_high_r  <= '1;
      left_low_r   <= '0;
      right_high_r <= '1;
      right_low_r  <= '0;
    end else begin
      left_high_r  <= left_high_nxt;
      left_low_r   <= left_low_nxt;
      right_high_r <= right_high_nxt;
      right_low_r  <= right_low_nxt;
    end
  end

  // Handshake: the result register moves when empty or taken, the input register follows.
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_take    = in_tvalid && in_tready;

  assign s1_valid_nxt   = in_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt  = s1_advance ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);
  assign band_depth_nxt = s1_advance ? step_result.depth_level : band_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      band_depth_r <= lss_pkg::DEPTH_CENTER;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      band_depth_r <= band_depth_nxt;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_left_r  <= in_tdata[15:0];
      s1_right_r <= in_tdata[31:16];
    end
    if (s1_advance) begin
      out_result_r <= step_result;
    end
  end

  // Band compare for each sensor.
  lss_band_cmp u_left_cmp (
    .sample   (s1_left_r),
    .cal_high (left_high_r),
    .cal_low  (left_low_r),
    .flags    (left_flags)
  );

  lss_band_cmp u_right_cmp (
    .sample   (s1_right_r),
    .cal_high (right_high_r),
    .cal_low  (right_low_r),
    .flags    (right_flags)
  );

  // Steering decision.
  lss_steer u_steer (
    .left_flags  (left_flags),
    .right_flags (right_flags),
    .depth_cur   (band_depth_r),
    .full_duty   (FullDuty),
    .result      (step_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_result_r};

`ifndef SYNTH
  // A shown result always carries the depth that the block keeps.
  a_depth_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_result_r.depth_level == band_depth_r))
    else $error("result depth differs from kept depth");

  // Position is centered exactly when depth is centered.
  a_center_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_result_r.line_position == lss_pkg::POS_CENTER) ==
                     (out_result_r.depth_level == lss_pkg::DEPTH_CENTER)))
    else $error("position and depth disagree on center");

  // The innermost band shows the outermost position.
  a_band1_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_result_r.depth_level == lss_pkg::DEPTH_BAND1) |->
      (out_result_r.line_position == lss_pkg::POS_LEFT3 ||
       out_result_r.line_position == lss_pkg::POS_RIGHT3))
    else $error("band one result with wrong position");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule

// ===== rtl/lss_band_cmp.sv =====
// Band thresholds and sample compare for one line sensor.
module lss_band_cmp (
  input  logic [lss_pkg::SampleW-1:0] sample,
  input  logic [lss_pkg::SampleW-1:0] cal_high,
  input  logic [lss_pkg::SampleW-1:0] cal_low,
  output lss_pkg::band_flags_t        flags
);

  logic [lss_pkg::SampleW-1:0] span;
  logic [lss_pkg::StepW-1:0]   step;
  logic [lss_pkg::LimitW-1:0]  low_ext;
  logic [lss_pkg::LimitW-1:0]  step_ext;
  logic [lss_pkg::LimitW-1:0]  lim1;
  logic [lss_pkg::LimitW-1:0]  lim2;
  logic [lss_pkg::LimitW-1:0]  lim3;

  // Quarter step of the calibrated span; the span wraps at 16 bits.
  assign span     = cal_high - cal_low;
  assign step     = span[lss_pkg::SampleW-1:2];
  assign low_ext  = {2'b00, cal_low};
  assign step_ext = {4'b0000, step};

  // Thresholds at one, two and three steps above the low reading.
  assign lim1 = low_ext + step_ext;
  assign lim2 = low_ext + {step_ext[lss_pkg::LimitW-2:0], 1'b0};
  assign lim3 = lim1 + {step_ext[lss_pkg::LimitW-2:0], 1'b0};

  // A sample is in a band when it is strictly below that threshold.
  assign flags.band1 = {2'b00, sample} < lim1;
  assign flags.band2 = {2'b00, sample} < lim2;
  assign flags.band3 = {2'b00, sample} < lim3;

endmodule

// ===== rtl/lss_steer.sv =====
// Prioritized steering decision from both sensors' band flags and the kept depth.
module lss_steer (
  input  lss_pkg::band_flags_t        left_flags,
  input  lss_pkg::band_flags_t        right_flags,
  input  logic [lss_pkg::DepthW-1:0]  depth_cur,
  input  logic [lss_pkg::DutyW-1:0]   full_duty,
  output lss_pkg::steer_result_t      result
);

  logic shallow_ok;

  // The outer band is only entered from depth two or less.
  assign shallow_ok = (depth_cur != lss_pkg::DEPTH_BAND1);

  // Inner band first; at each band a side is taken only when it alone is in it, else fall through.
  always_comb begin
    result.left_duty     = full_duty;
    result.right_duty    = full_duty;
    result.line_position = lss_pkg::POS_CENTER;
    result.depth_level   = lss_pkg::DEPTH_CENTER;
    if (left_flags.band1 && !right_flags.band1) begin
      result.right_duty    = lss_pkg::DUTY_BAND1;
      result.line_position = lss_pkg::POS_LEFT3;
      result.depth_level   = lss_pkg::DEPTH_BAND1;
    end else if (right_flags.band1 && !left_flags.band1) begin
      result.left_duty     = lss_pkg::DUTY_BAND1;
      result.line_position = lss_pkg::POS_RIGHT3;
      result.depth_level   = lss_pkg::DEPTH_BAND1;
    end else if (left_flags.band2 && !right_flags.band2) begin
      result.right_duty    = lss_pkg::DUTY_BAND2;
      result.line_position = lss_pkg::POS_LEFT2;
      result.depth_level   = lss_pkg::DEPTH_BAND2;
    end else if (right_flags.band2 && !left_flags.band2) begin
      result.left_duty     = lss_pkg::DUTY_BAND2;
      result.line_position = lss_pkg::POS_RIGHT2;
      result.depth_level   = lss_pkg::DEPTH_BAND2;
    end else if (left_flags.band3 && !right_flags.band3 && shallow_ok) begin
      result.right_duty    = lss_pkg::DUTY_BAND3;
      result.line_position = lss_pkg::POS_LEFT1;
      result.depth_level   = lss_pkg::DEPTH_BAND3;
    end else if (right_flags.band3 && !left_flags.band3 && shallow_ok) begin
      result.left_duty     = lss_pkg::DUTY_BAND3;
      result.line_position = lss_pkg::POS_RIGHT1;
      result.depth_level   = lss_pkg::DEPTH_BAND3;
    end
  end

endmodule
